[design/isotp_pkg.sv]
// Shared types and constants of the ISO-TP frame reassembler.
// Depends on nothing; every other design file imports it.
package isotp_pkg;

    // Message store geometry. The store is split into byte lanes, so that the
    // seven consecutive bytes of one frame land in seven different lanes.
    localparam int STORE_BYTES = 4096;
    localparam int LANES       = 8;
    localparam int LANE_BITS   = $clog2(LANES);
    localparam int LANE_DEPTH  = STORE_BYTES / LANES;
    localparam int ROW_W       = $clog2(LANE_DEPTH);

    // Field widths.
    localparam int ADDR_W = 12;
    localparam int LEN_W  = 12;
    localparam int SEQ_W  = 4;
    localparam int NUM_W  = 3;

    // Frame layout.
    localparam int SF_MAX_LEN    = 7;
    localparam int FF_DATA_BYTES = 6;
    localparam int CF_DATA_BYTES = 7;
    localparam int FRAME_BYTES   = 8;

    // Frame types in the high nibble of the PCI byte.
    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    // Request types.
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Sequence number expected after a first frame.
    localparam logic [SEQ_W-1:0] SEQ_FIRST = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WAIT = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } t_link_state;

    // One input word.
    typedef struct packed {
        logic              req_type;
        logic [7:0]        frame_byte0;
        logic [7:0]        frame_byte1;
        logic [7:0]        frame_byte2;
        logic [7:0]        frame_byte3;
        logic [7:0]        frame_byte4;
        logic [7:0]        frame_byte5;
        logic [7:0]        frame_byte6;
        logic [7:0]        frame_byte7;
        logic [ADDR_W-1:0] read_addr;
    } t_req;

    // One result word.
    typedef struct packed {
        logic [1:0]       link_status;
        logic [LEN_W-1:0] message_len;
        logic [LEN_W-1:0] bytes_received;
        logic             send_flow_control;
        logic [7:0]       read_data;
    } t_rsp;

    // Link context kept between frames.
    typedef struct packed {
        t_link_state      link_state;
        logic [LEN_W-1:0] total_len;
        logic [LEN_W-1:0] recv_count;
        logic [SEQ_W-1:0] next_seq;
    } t_link_ctx;

    // Write request towards one byte lane of the store.
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
    } t_lane_wr;

endpackage

[design/isotp_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on isotp_pkg for the payload types.
interface isotp_req_if;
    import isotp_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isotp_rsp_if;
    import isotp_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/isotp_frame_reassembler_top.sv]
// Top level of the ISO-TP frame reassembler: input register, frame decoder,
// lane-split message store and result register.
// Depends on isotp_pkg, isotp_if, isotp_frame_decode and isotp_lane_ram.
//
//   Port     Dir  Modport  Carries
//   i_req    in   sink     CAN frame or store read request, one word per item
//   o_rsp    out  source   link status, counters, flow-control flag, read byte
//
// A word accepted into the input register is decoded there; when the input register
// moves on, the store and the result register are written together.
// A new word is accepted every cycle while results are taken; all seven bytes of a
// frame go into the store at once because the store is eight byte lanes wide.
// Reset (synchronous, active low) empties both registers and sets the link idle;
// the store contents are not cleared. A stalled result holds the pipeline.
module isotp_frame_reassembler_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isotp_req_if.sink    i_req,
    isotp_rsp_if.source  o_rsp
);
    import isotp_pkg::*;

    logic                 r_s1_vld;
    t_req                 r_s1;
    logic                 adv;
    logic                 is_read;

    t_link_ctx            r_ctx;
    t_link_ctx            n_ctx;
    logic                 flow_ctrl;
    t_lane_wr             lane_wr [LANES];
    logic [7:0]           lane_q  [LANES];
    logic [ROW_W-1:0]     rd_row;

    logic                 r_out_vld;
    t_link_ctx            r_out_ctx;
    logic                 r_out_fc;
    logic                 r_out_is_read;
    logic                 r_out_in_range;
    logic [LANE_BITS-1:0] r_out_lane;

    // Handshake: the input register moves on when the result register is free.
    assign adv         = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || adv;
    assign is_read     = (r_s1.req_type == REQ_READ);
    assign rd_row      = ROW_W'(r_s1.read_addr >> LANE_BITS);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
        if (i_req.valid && i_req.ready) begin
            r_s1 <= i_req.data;
        end
    end

    isotp_frame_decode u_decode (
        .i_ctx       (r_ctx),
        .i_item      (r_s1),
        .o_ctx       (n_ctx),
        .o_flow_ctrl (flow_ctrl),
        .o_lane_wr   (lane_wr)
    );

    // Message store, one RAM per byte lane.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        isotp_lane_ram u_ram (
            .i_clk     (i_clk),
            .i_we      (adv && lane_wr[g].we),
            .i_wr_row  (lane_wr[g].row),
            .i_wr_data (lane_wr[g].data),
            .i_re      (adv && is_read),
            .i_rd_row  (rd_row),
            .o_rd_data (lane_q[g])
        );
    end

    // Link context.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{link_state: ST_IDLE, total_len: '0, recv_count: '0, next_seq: '0};
        end else if (adv) begin
            r_ctx <= n_ctx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv) begin
            r_out_ctx      <= n_ctx;
            r_out_fc       <= flow_ctrl;
            r_out_is_read  <= is_read;
            r_out_in_range <= ({1'b0, r_s1.read_addr} < (ADDR_W+1)'(STORE_BYTES));
            r_out_lane     <= r_s1.read_addr[LANE_BITS-1:0];
        end
    end

    // Result word.
    assign o_rsp.valid                  = r_out_vld;
    assign o_rsp.data.link_status       = r_out_ctx.link_state;
    assign o_rsp.data.message_len       = r_out_ctx.total_len;
    assign o_rsp.data.bytes_received    = r_out_ctx.recv_count;
    assign o_rsp.data.send_flow_control = r_out_fc;
    assign o_rsp.data.read_data         = (r_out_is_read && r_out_in_range) ?
                                          lane_q[r_out_lane] : 8'd0;

    // A flow-control request only comes with a freshly accepted first frame.
    a_fc_first_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.send_flow_control) |->
            (o_rsp.data.link_status == ST_WAIT &&
             o_rsp.data.bytes_received == LEN_W'(FF_DATA_BYTES)))
        else $error("flow-control request without a first frame");

    // A read access leaves the link context untouched.
    a_read_keeps_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_read) |=> $stable(r_ctx))
        else $error("read access changed the link context");

    // A read access never writes the store.
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && is_read) |-> (lane_wr[0].we == 1'b0 && lane_wr[1].we == 1'b0 &&
            lane_wr[2].we == 1'b0 && lane_wr[3].we == 1'b0 && lane_wr[4].we == 1'b0 &&
            lane_wr[5].we == 1'b0 && lane_wr[6].we == 1'b0 && lane_wr[7].we == 1'b0))
        else $error("read access wrote the store");

endmodule

[design/isotp_lane_ram.sv]
// One byte lane of the message store: one write and one registered read port.
// Depends on isotp_pkg for the lane depth.
module isotp_lane_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [isotp_pkg::ROW_W-1:0] i_wr_row,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_re,
    input  logic [isotp_pkg::ROW_W-1:0] i_rd_row,
    output logic [7:0]               o_rd_data
);
    import isotp_pkg::*;

    logic [7:0] r_mem [LANE_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/isotp_frame_decode.sv]
// Frame decoder: next link context and per-lane store writes for one word.
// Depends on isotp_pkg; purely combinational.
module isotp_frame_decode (
    input  isotp_pkg::t_link_ctx i_ctx,
    input  isotp_pkg::t_req      i_item,
    output isotp_pkg::t_link_ctx o_ctx,
    output logic                 o_flow_ctrl,
    output isotp_pkg::t_lane_wr  o_lane_wr [isotp_pkg::LANES]
);
    import isotp_pkg::*;

    logic [3:0]           kind;
    logic [3:0]           low;
    logic [LEN_W-1:0]     ff_len;
    logic [LEN_W-1:0]     rem;
    logic [NUM_W-1:0]     n_cf;
    logic [LEN_W-1:0]     rc_next;
    logic [LEN_W-1:0]     base;
    logic [NUM_W-1:0]     n_wr;
    logic                 from_byte2;
    logic [7:0]           fb [FRAME_BYTES+2];

    // Frame bytes as an array, padded with zeros past the last byte.
    always_comb begin
        fb[0] = i_item.frame_byte0;
        fb[1] = i_item.frame_byte1;
        fb[2] = i_item.frame_byte2;
        fb[3] = i_item.frame_byte3;
        fb[4] = i_item.frame_byte4;
        fb[5] = i_item.frame_byte5;
        fb[6] = i_item.frame_byte6;
        fb[7] = i_item.frame_byte7;
        fb[8] = 8'd0;
        fb[9] = 8'd0;
    end

    // Consecutive frame arithmetic: remaining count clamped at zero, at most
    // seven bytes per frame.
    always_comb begin
        kind    = i_item.frame_byte0[7:4];
        low     = i_item.frame_byte0[3:0];
        ff_len  = {low, i_item.frame_byte1};
        rem     = (i_ctx.total_len > i_ctx.recv_count) ?
                  (i_ctx.total_len - i_ctx.recv_count) : '0;
        n_cf    = (rem > LEN_W'(CF_DATA_BYTES)) ? NUM_W'(CF_DATA_BYTES) : rem[NUM_W-1:0];
        rc_next = i_ctx.recv_count + LEN_W'(n_cf);
    end

    // Link state update by frame type.
    always_comb begin
        o_ctx       = i_ctx;
        o_flow_ctrl = 1'b0;
        base        = '0;
        n_wr        = '0;
        from_byte2  = 1'b0;
        if (i_item.req_type == REQ_FRAME) begin
            case (kind)
                FT_SINGLE: begin
                    if (low <= 4'(SF_MAX_LEN)) begin
                        n_wr             = low[NUM_W-1:0];
                        o_ctx.total_len  = LEN_W'(low);
                        o_ctx.recv_count = LEN_W'(low);
                        o_ctx.link_state = ST_DONE;
                    end
                end
                FT_FIRST: begin
                    o_ctx.total_len = ff_len;
                    if ({1'b0, ff_len} > (LEN_W+1)'(STORE_BYTES)) begin
                        o_ctx.link_state = ST_ERR;
                    end else begin
                        n_wr             = NUM_W'(FF_DATA_BYTES);
                        from_byte2       = 1'b1;
                        o_ctx.recv_count = LEN_W'(FF_DATA_BYTES);
                        o_ctx.next_seq   = SEQ_FIRST;
                        o_ctx.link_state = ST_WAIT;
                        o_flow_ctrl      = 1'b1;
                    end
                end
                FT_CONSEC: begin
                    if (i_ctx.link_state == ST_WAIT) begin
                        if (low != i_ctx.next_seq) begin
                            o_ctx.link_state = ST_ERR;
                        end else begin
                            base             = i_ctx.recv_count;
                            n_wr             = n_cf;
                            o_ctx.recv_count = rc_next;
                            o_ctx.next_seq   = i_ctx.next_seq + 1'b1;
                            if (rc_next >= i_ctx.total_len) begin
                                o_ctx.link_state = ST_DONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Lane k takes the frame byte whose address falls into it; consecutive
    // addresses always hit distinct lanes.
    always_comb begin
        logic [LANE_BITS-1:0] off;
        logic [LEN_W:0]       addr;
        logic [3:0]           idx;
        for (int k = 0; k < LANES; k++) begin
            off  = LANE_BITS'(k) - base[LANE_BITS-1:0];
            addr = {1'b0, base} + (LEN_W+1)'(off);
            idx  = 4'(off) + (from_byte2 ? 4'd2 : 4'd1);
            o_lane_wr[k].we   = (NUM_W'(off) < n_wr) && (addr < (LEN_W+1)'(STORE_BYTES));
            o_lane_wr[k].row  = ROW_W'(addr >> LANE_BITS);
            o_lane_wr[k].data = fb[idx];
        end
    end

endmodule
